FILE: rtl/crc32_framed_file_header_checker_macros.svh
// Assertion macros for the file header checker.
`ifndef CRC32_FRAMED_FILE_HEADER_CHECKER_MACROS_SVH
`define CRC32_FRAMED_FILE_HEADER_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CFHC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cfhc: implication check failed");

`define CFHC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cfhc: next-cycle check failed");

`else

`define CFHC_ASSERT_IMP(label, clk, rst_n, pre, post)

`define CFHC_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/cfhc_pkg.sv
package cfhc_pkg;

    localparam int MAX_FILE_BYTES_DEF = 1024;
    localparam int HEADER_BYTES       = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
    localparam logic [15:0] HDR_LEN_CODE = 16'd16;

    localparam logic [31:0] MAGIC_RST   = 32'h4753_5950;
    localparam logic [15:0] VERSION_RST = 16'd1;
    localparam logic [9:0]  PAYLOAD_RST = 10'd132;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_CHECK   = 3'd5
    } status_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       take;    // below the read limit, updates state
        logic       is_hdr;  // one of the first HEADER_BYTES bytes
        logic [3:0] pos;     // byte position within the header
    } byte_item_t;

    localparam int ITEM_W = $bits(byte_item_t);
    localparam int RES_W  = 3 + 32;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/cfhc_fifo.sv
module cfhc_fifo #(
    parameter int WIDTH = cfhc_pkg::ITEM_W,
    parameter int DEPTH = cfhc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/cfhc_front.sv
module cfhc_front #(
    parameter int MAX_FILE_BYTES = cfhc_pkg::MAX_FILE_BYTES_DEF,
    parameter int CW             = $clog2(MAX_FILE_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 full,
    input  logic                 q_full,
    output logic                 q_push,
    output cfhc_pkg::byte_item_t q_item,
    output logic [CW-1:0]        q_count
);

    localparam logic [CW-1:0] LIMIT = CW'(MAX_FILE_BYTES);
    localparam logic [CW-1:0] HDR   = CW'(cfhc_pkg::HEADER_BYTES);

    logic [CW-1:0] count_reg, count_next;
    logic          take;
    logic [CW-1:0] count_inc;

    assign full      = q_full;
    assign q_push    = push && !q_full;
    assign take      = (count_reg < LIMIT);
    assign count_inc = take ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        q_item.data   = data_byte;
        q_item.last   = last_byte;
        q_item.take   = take;
        q_item.is_hdr = (count_reg < HDR);
        q_item.pos    = count_reg[3:0];
        q_count       = count_inc;   // file size once this byte is in
    end

    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            count_next = last_byte ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/cfhc_back.sv
module cfhc_back #(
    parameter int MAX_FILE_BYTES = cfhc_pkg::MAX_FILE_BYTES_DEF,
    parameter int CW             = $clog2(MAX_FILE_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  cfhc_pkg::byte_item_t q_item,
    input  logic [CW-1:0]        q_count,
    output logic                 q_pop,
    input  logic [31:0]          cfg_magic,
    input  logic [15:0]          cfg_version,
    input  logic [9:0]           cfg_payload,
    input  logic                 o_full,
    output logic                 o_push,
    output logic [2:0]           o_status,
    output logic [31:0]          o_check
);

    localparam logic [CW-1:0] LIMIT = CW'(MAX_FILE_BYTES);
    localparam logic [CW-1:0] HDR   = CW'(cfhc_pkg::HEADER_BYTES);

    // per-file state
    logic        magic_good_reg, magic_good_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] hdr_len_reg, hdr_len_next;
    logic [31:0] pay_len_reg, pay_len_next;
    logic [31:0] stored_reg, stored_next;
    logic [31:0] crc_reg, crc_next;

    // state after the popped byte, before any end-of-file clear
    logic        upd_magic;
    logic [15:0] upd_version, upd_hdr_len;
    logic [31:0] upd_pay_len, upd_stored, upd_crc;

    // snapshot of a finished file, held until its verdict is pushed
    logic          pend_valid_reg, pend_valid_next;
    logic          snap_magic_reg;
    logic [15:0]   snap_version_reg, snap_hdr_len_reg;
    logic [31:0]   snap_pay_len_reg, snap_stored_reg, snap_check_reg;
    logic [CW-1:0] snap_count_reg;

    logic          end_file;
    logic [32:0]   want;
    logic [32:0]   size;
    cfhc_pkg::status_t status;

    assign q_pop    = !q_empty && !(pend_valid_reg && o_full);
    assign end_file = q_pop && q_item.last;
    assign o_push   = pend_valid_reg && !o_full;

    always_comb
    begin
        upd_magic   = magic_good_reg;
        upd_version = version_reg;
        upd_hdr_len = hdr_len_reg;
        upd_pay_len = pay_len_reg;
        upd_stored  = stored_reg;
        upd_crc     = crc_reg;
        if (q_pop && q_item.take)
        begin
            if (q_item.is_hdr)
            begin
                unique case (q_item.pos[3:2])
                    2'd0:
                    begin
                        if (cfg_magic[q_item.pos[1:0]*8 +: 8] != q_item.data)
                        begin
                            upd_magic = 1'b0;
                        end
                    end
                    2'd1:
                    begin
                        if (!q_item.pos[1])
                        begin
                            upd_version[q_item.pos[0]*8 +: 8] =
                                version_reg[q_item.pos[0]*8 +: 8] | q_item.data;
                        end
                        else
                        begin
                            upd_hdr_len[q_item.pos[0]*8 +: 8] =
                                hdr_len_reg[q_item.pos[0]*8 +: 8] | q_item.data;
                        end
                    end
                    2'd2:
                    begin
                        upd_pay_len[q_item.pos[1:0]*8 +: 8] =
                            pay_len_reg[q_item.pos[1:0]*8 +: 8] | q_item.data;
                    end
                    default:
                    begin
                        upd_stored[q_item.pos[1:0]*8 +: 8] =
                            stored_reg[q_item.pos[1:0]*8 +: 8] | q_item.data;
                    end
                endcase
            end
            else
            begin
                upd_crc = cfhc_pkg::crc_byte(crc_reg, q_item.data);
            end
        end
    end

    always_comb
    begin
        if (end_file)
        begin
            magic_good_next = 1'b1;
            version_next    = '0;
            hdr_len_next    = '0;
            pay_len_next    = '0;
            stored_next     = '0;
            crc_next        = cfhc_pkg::CRC_ONES;
        end
        else
        begin
            magic_good_next = upd_magic;
            version_next    = upd_version;
            hdr_len_next    = upd_hdr_len;
            pay_len_next    = upd_pay_len;
            stored_next     = upd_stored;
            crc_next        = upd_crc;
        end
        if (pend_valid_reg && o_full)
        begin
            pend_valid_next = 1'b1;
        end
        else
        begin
            pend_valid_next = end_file;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_good_reg <= 1'b1;
            version_reg    <= '0;
            hdr_len_reg    <= '0;
            pay_len_reg    <= '0;
            stored_reg     <= '0;
            crc_reg        <= cfhc_pkg::CRC_ONES;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            magic_good_reg <= magic_good_next;
            version_reg    <= version_next;
            hdr_len_reg    <= hdr_len_next;
            pay_len_reg    <= pay_len_next;
            stored_reg     <= stored_next;
            crc_reg        <= crc_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_file)
        begin
            snap_magic_reg   <= upd_magic;
            snap_version_reg <= upd_version;
            snap_hdr_len_reg <= upd_hdr_len;
            snap_pay_len_reg <= upd_pay_len;
            snap_stored_reg  <= upd_stored;
            snap_check_reg   <= ~upd_crc;
            snap_count_reg   <= q_count;
        end
    end

    // verdict on the snapshot, in priority order
    assign want = {1'b0, snap_pay_len_reg} + 33'(cfhc_pkg::HEADER_BYTES);
    assign size = 33'(snap_count_reg);

    always_comb
    begin
        if (snap_count_reg >= LIMIT)
        begin
            status = cfhc_pkg::ST_LENGTH;
        end
        else if (snap_count_reg < HDR)
        begin
            status = cfhc_pkg::ST_TRUNC;
        end
        else if (!snap_magic_reg)
        begin
            status = cfhc_pkg::ST_MAGIC;
        end
        else if (snap_version_reg != cfg_version)
        begin
            status = cfhc_pkg::ST_VERSION;
        end
        else if (snap_hdr_len_reg != cfhc_pkg::HDR_LEN_CODE)
        begin
            status = cfhc_pkg::ST_LENGTH;
        end
        else if ((snap_pay_len_reg != {22'd0, cfg_payload}) || (size != want))
        begin
            status = (size < want) ? cfhc_pkg::ST_TRUNC : cfhc_pkg::ST_LENGTH;
        end
        else if (snap_check_reg != snap_stored_reg)
        begin
            status = cfhc_pkg::ST_CHECK;
        end
        else
        begin
            status = cfhc_pkg::ST_OK;
        end
    end

    assign o_status = status;
    assign o_check  = snap_check_reg;

endmodule

FILE: rtl/crc32_framed_file_header_checker.sv
// Channel   Ports                               Handshake
// input     data_byte, last_byte                push / full
// result    status, computed_check              pop / empty
// config    cfg_index, cfg_data                 cfg_valid / cfg_ready (always ready)
//
// One byte per cycle sustained while the result queue is not full; the CRC advances a whole byte per cycle.
// A result reaches the result ports after its final byte is taken, via the byte
// queue, the snapshot registers of the verdict stage and the result queue.
// Reset clears per-file state, both queues and loads register defaults; no
// clearing pass. Either side may stall alone; the two-entry queues absorb it.
`include "crc32_framed_file_header_checker_macros.svh"

module crc32_framed_file_header_checker #(
    parameter int MAX_FILE_BYTES = cfhc_pkg::MAX_FILE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] computed_check,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_FILE_BYTES + 1);

    logic [31:0] magic_reg, magic_next;
    logic [15:0] version_reg, version_next;
    logic [9:0]  payload_reg, payload_next;

    logic                 mid_push, mid_pop, mid_full, mid_empty;
    cfhc_pkg::byte_item_t front_item, back_item;
    logic [CW-1:0]        front_count, back_count;
    logic [cfhc_pkg::ITEM_W+CW-1:0] mid_rd;

    logic                        out_push, out_full;
    logic [2:0]                  res_status;
    logic [31:0]                 res_check;
    logic [cfhc_pkg::RES_W-1:0]  out_rd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        payload_next = payload_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cfhc_pkg::CFG_MAGIC:   magic_next   = cfg_data;
                cfhc_pkg::CFG_VERSION: version_next = cfg_data[15:0];
                cfhc_pkg::CFG_PAYLOAD: payload_next = cfg_data[9:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= cfhc_pkg::MAGIC_RST;
            version_reg <= cfhc_pkg::VERSION_RST;
            payload_reg <= cfhc_pkg::PAYLOAD_RST;
        end
        else
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
            payload_reg <= payload_next;
        end
    end

    cfhc_front #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .CW             (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .full      (full),
        .q_full    (mid_full),
        .q_push    (mid_push),
        .q_item    (front_item),
        .q_count   (front_count)
    );

    cfhc_fifo #(
        .WIDTH (cfhc_pkg::ITEM_W + CW),
        .DEPTH (cfhc_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data ({front_item, front_count}),
        .rd_en   (mid_pop),
        .rd_data (mid_rd),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    assign back_item  = cfhc_pkg::byte_item_t'(mid_rd[cfhc_pkg::ITEM_W+CW-1:CW]);
    assign back_count = mid_rd[CW-1:0];

    cfhc_back #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES),
        .CW             (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (mid_empty),
        .q_item      (back_item),
        .q_count     (back_count),
        .q_pop       (mid_pop),
        .cfg_magic   (magic_reg),
        .cfg_version (version_reg),
        .cfg_payload (payload_reg),
        .o_full      (out_full),
        .o_push      (out_push),
        .o_status    (res_status),
        .o_check     (res_check)
    );

    cfhc_fifo #(
        .WIDTH (cfhc_pkg::RES_W),
        .DEPTH (cfhc_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data ({res_status, res_check}),
        .rd_en   (pop),
        .rd_data (out_rd),
        .full    (out_full),
        .empty   (empty)
    );

    assign status         = out_rd[cfhc_pkg::RES_W-1:32];
    assign computed_check = out_rd[31:0];

    `CFHC_ASSERT_IMP(a_mid_room, clk, rst_n, mid_push, !mid_full)
    `CFHC_ASSERT_IMP(a_out_room, clk, rst_n, out_push, !out_full)
    `CFHC_ASSERT_IMP(a_status_code, clk, rst_n, !empty, status <= cfhc_pkg::ST_CHECK)
    `CFHC_ASSERT_NEXT(a_mid_fill, clk, rst_n, mid_push && !mid_pop, !mid_empty)

endmodule
